// ===== hdl/sbgce_pkg.sv =====
// shared constants and types of the swept box grid cell enumerator
`default_nettype none
package sbgce_pkg;

  localparam int CoordW      = 16;
  localparam int SizeW       = 12;
  localparam int VelW        = 12;
  localparam int CellW       = 17;
  localparam int CfgW        = 11;
  localparam int MagW        = 16;
  localparam int DivStages   = 4;
  localparam int DivBits     = MagW / DivStages;
  localparam int MaxCellsDef = 64;
  localparam int Margin      = 1;
  localparam logic [CfgW-1:0] CellSizeRst = 11'd32;

  typedef struct packed {
    logic signed [CellW-1:0] x0;
    logic signed [CellW-1:0] x1;
    logic signed [CellW-1:0] y0;
    logic signed [CellW-1:0] y1;
  } sbgce_bounds_t;

endpackage
`default_nettype wire

// ===== hdl/swept_box_grid_cell_enumerator_core.sv =====
// top level of the swept box grid cell enumerator
`default_nettype none
// Takes one moving box per transfer and sends out, one transfer per cell,
// every grid cell of the swept box (current and next position) with a
// margin of one cell, rows outer and columns inner, at most MAX_CELLS cells.
// A box runs through a front pipeline of seven register stages (sweep,
// magnitude, four divider stages of four quotient bits each, bounds) and
// then into the cell walker, which sends one cell per cycle unless the
// output is stalled. A box holds the walker until its last cell is sent and
// the walker takes no new box before then; following boxes queue in the
// front pipeline. cell_size is taken as 1 when written as 0 and must only
// be written while the block is idle.
module swept_box_grid_cell_enumerator_core
  import sbgce_pkg::*;
#(
  parameter int MAX_CELLS = MaxCellsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgW-1:0]          cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] pos_x_i,
  input  wire logic signed [CoordW-1:0] pos_y_i,
  input  wire logic [SizeW-1:0]         box_width_i,
  input  wire logic [SizeW-1:0]         box_height_i,
  input  wire logic signed [VelW-1:0]   vel_x_i,
  input  wire logic signed [VelW-1:0]   vel_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [CellW-1:0]       cell_x_o,
  output logic signed [CellW-1:0]       cell_y_o,
  output logic                          last_cell_o,
  output logic                          overflow_o
);

  // cell size register
  logic [CfgW-1:0] cell_size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cell_size_q <= CellSizeRst;
    else if (cfg_we_i) cell_size_q <= cfg_wdata_i;
  end

  // the front pipeline moves as one; it halts only when the bounds stage
  // holds a box that the walker cannot take yet
  logic en, take;
  logic v1_q, v2_q, vb_q;
  logic [DivStages-1:0] vd_q;
  assign en         = !vb_q || take;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
      vb_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      vd_q <= {vd_q[DivStages-2:0], v2_q};
      vb_q <= vd_q[DivStages-1];
    end
  end

  // sweep: upper-left corner and lower-right edge of the swept box
  logic signed [CellW-1:0] nx, ny, tx, ty, mx, my;
  always_comb begin
    nx = CellW'(pos_x_i) + CellW'(vel_x_i);
    ny = CellW'(pos_y_i) + CellW'(vel_y_i);
    tx = ($signed(CellW'(pos_x_i)) < nx) ? CellW'(pos_x_i) : nx;
    ty = ($signed(CellW'(pos_y_i)) < ny) ? CellW'(pos_y_i) : ny;
    mx = ($signed(CellW'(pos_x_i)) < nx) ? nx : CellW'(pos_x_i);
    my = ($signed(CellW'(pos_y_i)) < ny) ? ny : CellW'(pos_y_i);
  end

  // dividend order: ulx, uly, lrx, lry
  logic signed [CellW-1:0] s1_q [4];
  logic [CfgW-1:0]         g1_q, g2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q[0] <= tx;
      s1_q[1] <= ty;
      s1_q[2] <= mx + CellW'(box_width_i);
      s1_q[3] <= my + CellW'(box_height_i);
      g1_q    <= (cell_size_q == '0) ? CfgW'(1) : cell_size_q;
      g2_q    <= g1_q;
    end
  end

  logic signed [CellW-1:0] quot [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    logic            neg_q;
    logic [MagW-1:0] mag_q;
    logic [CellW-1:0] abs_v;
    assign abs_v = s1_q[k][CellW-1] ? -s1_q[k] : s1_q[k];
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q <= s1_q[k][CellW-1];
        mag_q <= abs_v[MagW-1:0];
      end
    end
    sbgce_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .neg_i  (neg_q),
      .mag_i  (mag_q),
      .div_i  (g2_q),
      .quot_o (quot[k])
    );
  end

  // margin and corner ordering
  sbgce_bounds_t bnd_d, bnd_q;
  always_comb begin
    logic signed [CellW-1:0] ulxm, lrxp, ulym, lryp;
    ulxm = quot[0] - CellW'(Margin);
    lrxp = quot[2] + CellW'(Margin);
    ulym = quot[1] - CellW'(Margin);
    lryp = quot[3] + CellW'(Margin);
    if (ulxm < lrxp) begin
      bnd_d.x0 = ulxm;
      bnd_d.x1 = lrxp;
    end else begin
      bnd_d.x0 = quot[2] - CellW'(Margin);
      bnd_d.x1 = quot[0] + CellW'(Margin);
    end
    if (ulym < lryp) begin
      bnd_d.y0 = ulym;
      bnd_d.y1 = lryp;
    end else begin
      bnd_d.y0 = quot[3] - CellW'(Margin);
      bnd_d.y1 = quot[1] + CellW'(Margin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) bnd_q <= bnd_d;
  end

  sbgce_enum #(
    .MAX_CELLS (MAX_CELLS)
  ) u_enum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (vb_q),
    .bnd_i        (bnd_q),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .last_cell_o  (last_cell_o),
    .overflow_o   (overflow_o)
  );

endmodule
`default_nettype wire

// ===== hdl/sbgce_div.sv =====
// pipelined truncating signed divider, four quotient bits per stage
`default_nettype none
module sbgce_div
  import sbgce_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic                    neg_i,
  input  wire logic [MagW-1:0]         mag_i,
  input  wire logic [CfgW-1:0]         div_i,
  output logic signed [CellW-1:0]      quot_o
);

  logic            neg_q [DivStages];
  logic [MagW-1:0] mag_q [DivStages];
  logic [MagW-1:0] quo_q [DivStages];
  logic [CfgW-1:0] rem_q [DivStages];
  logic [CfgW-1:0] dvs_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic            neg_in;
    logic [MagW-1:0] mag_in;
    logic [MagW-1:0] quo_in;
    logic [CfgW-1:0] rem_in;
    logic [CfgW-1:0] dvs_in;
    logic [MagW-1:0] quo_d;
    logic [CfgW-1:0] rem_d;

    if (s == 0) begin : g_first
      assign neg_in = neg_i;
      assign mag_in = mag_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign dvs_in = div_i;
    end else begin : g_next
      assign neg_in = neg_q[s-1];
      assign mag_in = mag_q[s-1];
      assign quo_in = quo_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dvs_in = dvs_q[s-1];
    end

    // restoring steps over this stage's dividend bits
    always_comb begin
      logic [CfgW:0] r;
      r     = {1'b0, rem_in};
      quo_d = quo_in;
      for (int j = 0; j < DivBits; j++) begin
        r     = {r[CfgW-1:0], mag_in[MagW-1-s*DivBits-j]};
        quo_d = {quo_d[MagW-2:0], 1'b0};
        if (r >= {1'b0, dvs_in}) begin
          r        = r - {1'b0, dvs_in};
          quo_d[0] = 1'b1;
        end
      end
      rem_d = r[CfgW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[s] <= neg_in;
        mag_q[s] <= mag_in;
        quo_q[s] <= quo_d;
        rem_q[s] <= rem_d;
        dvs_q[s] <= dvs_in;
      end
    end
  end

  // truncation toward zero: negate the magnitude quotient
  always_comb begin
    logic [CellW-1:0] q;
    q      = {1'b0, quo_q[DivStages-1]};
    quot_o = neg_q[DivStages-1] ? -q : q;
  end

endmodule
`default_nettype wire

// ===== hdl/sbgce_enum.sv =====
// row by row cell walker with count cap and output register
`default_nettype none
module sbgce_enum
  import sbgce_pkg::*;
#(
  parameter int MAX_CELLS = MaxCellsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_valid_i,
  input  wire sbgce_bounds_t           bnd_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [CellW-1:0]      cell_x_o,
  output logic signed [CellW-1:0]      cell_y_o,
  output logic                         last_cell_o,
  output logic                         overflow_o
);

  localparam int NW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  logic                    busy_q, ov_q;
  logic signed [CellW-1:0] x_q, y_q, x0_q, x1_q, y1_q;
  logic [NW-1:0]           n_q;
  logic signed [CellW-1:0] cx_q, cy_q;
  logic                    last_q, ovf_q;

  logic slot_free, row_end, all_end, cap, last;

  assign slot_free = !ov_q || !out_stall_i;
  assign row_end   = (x_q + CellW'(1)) == x1_q;
  assign all_end   = row_end && ((y_q + CellW'(1)) == y1_q);
  assign cap       = n_q == NW'(MAX_CELLS - 1);
  assign last      = all_end || cap;
  assign take_o    = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (busy_q && slot_free) begin
        ov_q <= 1'b1;
        if (last) busy_q <= 1'b0;
      end else if (slot_free) begin
        ov_q <= 1'b0;
      end
      if (!busy_q && load_valid_i) busy_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && load_valid_i) begin
      x_q  <= bnd_i.x0;
      y_q  <= bnd_i.y0;
      x0_q <= bnd_i.x0;
      x1_q <= bnd_i.x1;
      y1_q <= bnd_i.y1;
      n_q  <= '0;
    end else if (busy_q && slot_free) begin
      cx_q   <= x_q;
      cy_q   <= y_q;
      last_q <= last;
      ovf_q  <= cap && !all_end;
      n_q    <= n_q + NW'(1);
      if (row_end) begin
        x_q <= x0_q;
        y_q <= y_q + CellW'(1);
      end else begin
        x_q <= x_q + CellW'(1);
      end
    end
  end

  assign out_valid_o = ov_q;
  assign cell_x_o    = cx_q;
  assign cell_y_o    = cy_q;
  assign last_cell_o = last_q;
  assign overflow_o  = ovf_q;

endmodule
`default_nettype wire

// ===== hdl/sbgce_checker.sv =====
// port level checks of the enumerator and their binding
`default_nettype none
module sbgce_checker
  import sbgce_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic signed [CellW-1:0] cell_x_o,
  input wire logic                    last_cell_o,
  input wire logic                    overflow_o
);

  // overflow only ever marks the final cell
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_cell_o)
    else $error("overflow without last cell");

  // within a box the next cell follows right after a transfer
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_cell_o |=> out_valid_o)
    else $error("gap inside a box");

  // a stalled cell holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_x_o))
    else $error("stalled cell changed");

endmodule

bind swept_box_grid_cell_enumerator_core sbgce_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cell_x_o    (cell_x_o),
  .last_cell_o (last_cell_o),
  .overflow_o  (overflow_o)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the swept box grid cell enumerator core
`timescale 1ns / 1ps
`default_nettype none

class cell_scoreboard;
  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               last;
    logic               ovf;
  } cell_t;

  cell_t      pending_cells[$];
  logic [10:0] grid_size;
  int         errors;
  int         boxes;
  int         cells;
  int         cut_boxes;

  function new();
    grid_size = 11'd32;
    errors    = 0;
    boxes     = 0;
    cells     = 0;
    cut_boxes = 0;
  endfunction

  // swept box to cell list, truncating division toward zero
  function void note_box(logic signed [15:0] px, logic signed [15:0] py,
                         logic [11:0] w, logic [11:0] h,
                         logic signed [11:0] vx, logic signed [11:0] vy);
    longint g, nx, ny, tx, ty, tw, th, ulx, uly, lrx, lry;
    longint x0, x1, y0, y1, total, emit, n;
    bit     cut;
    cell_t  c;
    g  = (grid_size == 0) ? 1 : longint'(grid_size);
    nx = longint'(px) + longint'(vx);
    ny = longint'(py) + longint'(vy);
    tx = (px < nx) ? longint'(px) : nx;
    ty = (py < ny) ? longint'(py) : ny;
    tw = ((px > nx) ? longint'(px) : nx) - tx + longint'(w);
    th = ((py > ny) ? longint'(py) : ny) - ty + longint'(h);
    ulx = tx / g;
    uly = ty / g;
    lrx = (tx + tw) / g;
    lry = (ty + th) / g;
    if (uly - 1 < lry + 1) begin
      y0 = uly - 1; y1 = lry + 1;
    end else begin
      y0 = lry - 1; y1 = uly + 1;
    end
    if (ulx - 1 < lrx + 1) begin
      x0 = ulx - 1; x1 = lrx + 1;
    end else begin
      x0 = lrx - 1; x1 = ulx + 1;
    end
    total = (y1 - y0) * (x1 - x0);
    cut   = total > 64;
    emit  = cut ? 64 : total;
    n     = 0;
    for (longint y = y0; y < y1 && n < emit; y++) begin
      for (longint x = x0; x < x1 && n < emit; x++) begin
        c.x    = x[16:0];
        c.y    = y[16:0];
        c.last = (n + 1 == emit);
        c.ovf  = c.last && cut;
        pending_cells = {pending_cells, c};
        n++;
      end
    end
    boxes++;
    if (cut) cut_boxes++;
  endfunction

  function void check_cell(logic signed [16:0] x, logic signed [16:0] y,
                           logic last, logic ovf);
    cell_t e;
    cells++;
    if (pending_cells.size() == 0) begin
      $display("%0t: unexpected cell x=%0d y=%0d last=%0b ovf=%0b",
               $time, x, y, last, ovf);
      errors++;
      return;
    end
    e = pending_cells.pop_front();
    if (e.x !== x || e.y !== y || e.last !== last || e.ovf !== ovf) begin
      $display("%0t: cell mismatch expected x=%0d y=%0d last=%0b ovf=%0b",
               $time, e.x, e.y, e.last, e.ovf);
      $display("%0t:                 actual x=%0d y=%0d last=%0b ovf=%0b",
               $time, x, y, last, ovf);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sbgce_pkg::*;

  localparam int CfgIndex = 0;
  localparam int WatchdogLimit = 20000;

  // receiver behavior codes
  localparam int RxRandom = 0;
  localparam int RxNoIdle = 1;
  localparam int RxHold   = 2;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CfgW-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [CoordW-1:0] pos_x = '0;
  logic signed [CoordW-1:0] pos_y = '0;
  logic [SizeW-1:0]         box_w = '0;
  logic [SizeW-1:0]         box_h = '0;
  logic signed [VelW-1:0]   vel_x = '0;
  logic signed [VelW-1:0]   vel_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b1;
  logic signed [CellW-1:0]  cell_x;
  logic signed [CellW-1:0]  cell_y;
  logic                     last_cell;
  logic                     overflow;

  cell_scoreboard sb = new();

  // receiver behavior: random idling, never idle, or long hold-off
  int  rx_mode = RxRandom;
  bit  tx_no_idle = 1'b0;
  int  idle_cycles = 0;

  swept_box_grid_cell_enumerator_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .box_width_i (box_w),
    .box_height_i(box_h),
    .vel_x_i     (vel_x),
    .vel_y_i     (vel_y),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cell_x_o    (cell_x),
    .cell_y_o    (cell_y),
    .last_cell_o (last_cell),
    .overflow_o  (overflow)
  );

  always #10 clk = ~clk;

  // result side: check each accepted transfer and pick the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_cell(cell_x, cell_y, last_cell, overflow);
      case (rx_mode)
        RxNoIdle: out_stall <= 1'b0;
        RxHold:   out_stall <= 1'b1;
        default:  out_stall <= ($urandom_range(99) < 28);
      endcase
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("[swept_box_grid_cell_enumerator_core] ERROR");
      $finish;
    end
  end

  // one box transfer, with random idling before it unless switched off
  task automatic send_box(logic signed [15:0] px, logic signed [15:0] py,
                          logic [11:0] w, logic [11:0] h,
                          logic signed [11:0] vx, logic signed [11:0] vy);
    while (!tx_no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= px;
    pos_y    <= py;
    box_w    <= w;
    box_h    <= h;
    vel_x    <= vx;
    vel_y    <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_box(px, py, w, h, vx, vy);
  endtask

  // drain and settle before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cell_size(logic [10:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (CfgIndex == 0) sb.grid_size = v;
  endtask

  // mostly small boxes so cells stay near the typical count
  task automatic send_random_box();
    logic [11:0] w, h;
    logic signed [11:0] vx, vy;
    if ($urandom_range(9) == 0) begin
      w  = 12'($urandom());
      h  = 12'($urandom());
      vx = 12'($urandom());
      vy = 12'($urandom());
    end else begin
      w  = 12'($urandom_range(80));
      h  = 12'($urandom_range(80));
      vx = 12'($urandom_range(60)) - 12'd30;
      vy = 12'($urandom_range(60)) - 12'd30;
    end
    send_box(16'($urandom()), 16'($urandom()), w, h, vx, vy);
  endtask

  initial begin
    logic [10:0] sizes[6];
    sizes = '{11'd32, 11'd1, 11'd0, 11'd1024, 11'd2047, 11'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed boxes at reset cell size
    send_box(16'sd0, 16'sd0, 12'd0, 12'd0, 12'sd0, 12'sd0);
    send_box(16'sd10, 16'sd10, 12'd10, 12'd10, 12'sd0, 12'sd0);
    send_box(-16'sd33, -16'sd1, 12'd5, 12'd5, 12'sd3, -12'sd3);
    send_box(16'sh7fff, 16'sh7fff, 12'hfff, 12'hfff, 12'sh7ff, 12'sh7ff);
    send_box(-16'sh8000, -16'sh8000, 12'hfff, 12'hfff, -12'sh800, -12'sh800);
    send_box(16'sd0, 16'sd0, 12'd191, 12'd191, 12'sd0, 12'sd0); // 7x7 cells
    send_box(16'sd0, 16'sd0, 12'd192, 12'd191, 12'sd0, 12'sd0); // one column more, 8x7 cells
    send_box(16'sd100, -16'sd100, 12'd0, 12'd40, -12'sd50, 12'sd50);
    send_box(-16'sd31, 16'sd31, 12'd1, 12'd1, 12'sd1, -12'sd1);
    wait_drained();

    write_cell_size(11'd0);
    send_box(16'sd0, 16'sd0, 12'd0, 12'd0, 12'sd0, 12'sd0);
    send_box(-16'sd3, 16'sd2, 12'd5, 12'd0, 12'sd1, 12'sd0);
    wait_drained();
    write_cell_size(11'd2047);
    send_box(16'sh7fff, -16'sh8000, 12'hfff, 12'hfff, 12'sh7ff, -12'sh800);
    send_box(-16'sd2047, 16'sd2047, 12'd1, 12'd1, 12'sd0, 12'sd0);
    wait_drained();

    // random phases over several cell sizes
    foreach (sizes[i]) begin
      write_cell_size(sizes[i]);
      if (i == 1) begin
        tx_no_idle = 1'b1;
        rx_mode    = RxNoIdle;
      end
      for (int k = 0; k < 40; k++) send_random_box();
      tx_no_idle = 1'b0;
      rx_mode    = RxRandom;
      wait_drained();
    end

    // receiver holds off while boxes keep coming so the input backs up
    write_cell_size(11'd16);
    fork
      begin
        rx_mode = RxHold;
        repeat (600) @(posedge clk);
        rx_mode = RxRandom;
      end
      begin
        for (int k = 0; k < 60; k++) send_random_box();
        in_valid <= 1'b0;
      end
    join
    wait_drained();
    write_cell_size(11'($urandom_range(1, 1024)));
    for (int k = 0; k < 60; k++) send_random_box();
    wait_drained();

    $display("covered %0d boxes, %0d cells, %0d boxes cut at the cell limit",
             sb.boxes, sb.cells, sb.cut_boxes);
    if (sb.errors == 0 && sb.pending_cells.size() == 0)
      $display("[swept_box_grid_cell_enumerator_core] OK");
    else
      $display("[swept_box_grid_cell_enumerator_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
